// ===== hw/rtl/linear_probe_hash_table_unit_assert.svh =====
// Assertion macros for the hash table unit.
`ifndef LINEAR_PROBE_HASH_TABLE_UNIT_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define LPHT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define LPHT_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define LPHT_ASSERT(lbl, clk, rstn, prop, msg)
`define LPHT_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ===== hw/rtl/lpht_pkg.sv =====
package lpht_pkg;

  localparam int unsigned KeyW    = 31;
  localparam int unsigned SlotW   = 4;
  localparam int unsigned CfgW    = 5;
  localparam int unsigned BitCntW = $clog2(KeyW);

  localparam logic ActInsert = 1'b0;
  localparam logic ActSearch = 1'b1;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StNotFound = 2'd1,
    StFull     = 2'd2
  } status_e;

  typedef struct packed {
    logic clr_wr;
    logic load;
    logic div_step;
    logic reduce_step;
    logic home_load;
    logic rd_home;
    logic probe_adv;
    logic ins_wr;
    logic res_load;
    logic res_found;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_last;
    logic rem_in_range;
    logic hit;
    logic probe_last;
    logic is_search;
  } sts_t;

  // trial division by repeated subtraction, elaboration only
  function automatic int unsigned largest_prime(input int unsigned n);
    int unsigned best;
    int unsigned r;
    bit          prime;
    best = 1;
    for (int unsigned c = 2; c <= n; c++) begin
      prime = 1'b1;
      for (int unsigned d = 2; d < c; d++) begin
        r = c;
        while (r >= d) r = r - d;
        if (r == 0) prime = 1'b0;
      end
      if (prime) best = c;
    end
    return best;
  endfunction

endpackage

// ===== hw/rtl/lpht_in_if.sv =====
interface lpht_in_if;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [lpht_pkg::KeyW-1:0] key;

  modport source (output valid, output action, output key, input ready);
  modport sink (input valid, input action, input key, output ready);
endinterface

// ===== hw/rtl/lpht_out_if.sv =====
interface lpht_out_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic [lpht_pkg::SlotW-1:0] slot_index;

  modport source (output valid, output status, output slot_index, input ready);
  modport sink (input valid, input status, input slot_index, output ready);
endinterface

// ===== hw/rtl/linear_probe_hash_table_unit.sv =====
// Open-addressing hash table, linear probing, division-method home slot.
// Input channel in_i carries action (0 insert, 1 search) and a 31-bit key;
// an item is taken when valid and ready are both high. Output channel out_o
// returns one result per item: status (0 ok, 1 not found, 2 full) and
// slot_index. cfg_we_i/cfg_wdata_i write the hash modulus (0 acts as 1).
// Per item: a load step, a bit-serial remainder over the key bits, then
// folding the remainder below TABLE_SIZE by subtracting TABLE_SIZE (no
// subtraction unless the modulus exceeds the table size), a home read,
// then one probe step per slot probed (1 to TABLE_SIZE) through the
// single-port slot store.
// One item is in flight.
// After reset the store is cleared one slot a cycle,
// with in_i.ready low; the modulus resets to the largest prime not above
// TABLE_SIZE. A result waits in the output register while out_o.ready is
// low; the next item is accepted and worked on meanwhile, and its result
// holds in the probe stage until the register is free.
module linear_probe_hash_table_unit #(
  parameter int unsigned TABLE_SIZE = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [lpht_pkg::CfgW-1:0] cfg_wdata_i,
  lpht_in_if.sink                   in_i,
  lpht_out_if.source                out_o
);

  localparam int unsigned TsBits   = $clog2(TABLE_SIZE + 1);
  localparam int unsigned ModW     = (TsBits > lpht_pkg::CfgW) ? TsBits : lpht_pkg::CfgW;
  localparam int unsigned ModReset = lpht_pkg::largest_prime(TABLE_SIZE);

  lpht_pkg::cmd_t cmd;
  lpht_pkg::sts_t sts;

  lpht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lpht_dp #(
    .TABLE_SIZE (TABLE_SIZE),
    .ModW       (ModW),
    .ModReset   (ModReset)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_action_i  (in_i.action),
    .in_key_i     (in_i.key),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_status_o (out_o.status),
    .out_slot_o   (out_o.slot_index)
  );

endmodule

// ===== hw/rtl/lpht_dp.sv =====
module lpht_dp #(
  parameter int unsigned TABLE_SIZE = 16,
  parameter int unsigned ModW       = 5,
  parameter int unsigned ModReset   = 13
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lpht_pkg::CfgW-1:0]   cfg_wdata_i,
  input  logic                        in_action_i,
  input  logic [lpht_pkg::KeyW-1:0]   in_key_i,
  input  lpht_pkg::cmd_t              cmd_i,
  output lpht_pkg::sts_t              sts_o,
  output logic [1:0]                  out_status_o,
  output logic [lpht_pkg::SlotW-1:0]  out_slot_o
);

  localparam int unsigned AW   = $clog2(TABLE_SIZE);
  localparam int unsigned KW   = lpht_pkg::KeyW;
  localparam int unsigned SW   = lpht_pkg::SlotW;
  localparam logic [AW-1:0] LastPos = AW'(TABLE_SIZE - 1);
  localparam logic [ModW-1:0] TsW   = ModW'(TABLE_SIZE);
  localparam logic [lpht_pkg::BitCntW-1:0] DivLast = lpht_pkg::BitCntW'(KW - 1);

  logic [ModW-1:0]              mod_q;
  logic                         act_q;
  logic [KW-1:0]                key_q;
  logic [KW-1:0]                key_sh_q;
  logic [ModW-1:0]              rem_q, rem_d;
  logic [lpht_pkg::BitCntW-1:0] bit_cnt_q;
  logic [AW-1:0]                pos_q, pos_inc;
  logic [AW-1:0]                cnt_q;
  logic [KW:0]                  rd_q;
  logic [1:0]                   out_status_q;
  logic [SW-1:0]                out_slot_q;
  logic [KW:0]                  mem [TABLE_SIZE];

  logic [ModW-1:0]  m_eff;
  logic [ModW:0]    shifted, diff;
  logic             wr_en, rd_en;
  logic [AW-1:0]    rd_addr;
  logic [KW:0]      wr_data;
  logic [AW+SW-1:0] slot_ext;

  assign m_eff   = (mod_q == '0) ? ModW'(1) : mod_q;
  assign shifted = {rem_q, key_sh_q[KW-1]};
  assign diff    = shifted - {1'b0, m_eff};
  assign rem_d   = (shifted >= {1'b0, m_eff}) ? diff[ModW-1:0] : shifted[ModW-1:0];
  assign pos_inc = (pos_q == LastPos) ? '0 : pos_q + AW'(1);

  assign wr_en   = cmd_i.clr_wr | cmd_i.ins_wr;
  assign wr_data = cmd_i.clr_wr ? '0 : {1'b1, key_q};
  assign rd_en   = cmd_i.rd_home | cmd_i.probe_adv;
  assign rd_addr = cmd_i.probe_adv ? pos_inc : pos_q;
  assign slot_ext = {SW'(0), pos_q};

  assign sts_o.clr_last     = (pos_q == LastPos);
  assign sts_o.div_last     = (bit_cnt_q == DivLast);
  assign sts_o.rem_in_range = (rem_q < TsW);
  assign sts_o.hit          = (act_q == lpht_pkg::ActSearch)
                              ? (rd_q[KW] && (rd_q[KW-1:0] == key_q)) : !rd_q[KW];
  assign sts_o.probe_last   = (cnt_q == LastPos);
  assign sts_o.is_search    = (act_q == lpht_pkg::ActSearch);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= ModW'(ModReset);
      pos_q <= '0;
    end else begin
      if (cfg_we_i) begin
        mod_q <= ModW'(cfg_wdata_i);
      end
      if (cmd_i.clr_wr || cmd_i.probe_adv) begin
        pos_q <= pos_inc;
      end else if (cmd_i.home_load) begin
        pos_q <= rem_q[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q     <= in_action_i;
      key_q     <= in_key_i;
      key_sh_q  <= in_key_i;
      rem_q     <= '0;
      bit_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      key_sh_q  <= {key_sh_q[KW-2:0], 1'b0};
      rem_q     <= rem_d;
      bit_cnt_q <= bit_cnt_q + lpht_pkg::BitCntW'(1);
    end else if (cmd_i.reduce_step) begin
      rem_q <= rem_q - TsW;
    end
    if (cmd_i.rd_home) begin
      cnt_q <= '0;
    end else if (cmd_i.probe_adv) begin
      cnt_q <= cnt_q + AW'(1);
    end
    if (cmd_i.res_load) begin
      if (cmd_i.res_found) begin
        out_status_q <= lpht_pkg::StOk;
        out_slot_q   <= slot_ext[SW-1:0];
      end else begin
        out_status_q <= (act_q == lpht_pkg::ActSearch) ? lpht_pkg::StNotFound
                                                       : lpht_pkg::StFull;
        out_slot_q   <= '0;
      end
    end
  end

  // slot store: {valid, key}
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[pos_q] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign out_status_o = out_status_q;
  assign out_slot_o   = out_slot_q;

endmodule

// ===== hw/rtl/lpht_ctrl.sv =====
`include "linear_probe_hash_table_unit_assert.svh"

module lpht_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  lpht_pkg::sts_t sts_i,
  output lpht_pkg::cmd_t cmd_o
);

  localparam logic [2:0] StateClear  = 3'd0;
  localparam logic [2:0] StateIdle   = 3'd1;
  localparam logic [2:0] StateDiv    = 3'd2;
  localparam logic [2:0] StateReduce = 3'd3;
  localparam logic [2:0] StateRead   = 3'd4;
  localparam logic [2:0] StateCheck  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       finish;

  assign out_free = !out_valid_q || out_ready_i;
  assign finish   = sts_i.hit || sts_i.probe_last;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StateClear: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) state_d = StateIdle;
      end
      StateIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StateDiv;
        end
      end
      StateDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = StateReduce;
      end
      StateReduce: begin
        if (sts_i.rem_in_range) begin
          cmd_o.home_load = 1'b1;
          state_d         = StateRead;
        end else begin
          cmd_o.reduce_step = 1'b1;
        end
      end
      StateRead: begin
        cmd_o.rd_home = 1'b1;
        state_d       = StateCheck;
      end
      StateCheck: begin
        if (!finish) begin
          cmd_o.probe_adv = 1'b1;
        end else if (out_free) begin
          cmd_o.res_load  = 1'b1;
          cmd_o.res_found = sts_i.hit;
          cmd_o.ins_wr    = sts_i.hit && !sts_i.is_search;
          state_d         = StateIdle;
        end
      end
      default: state_d = StateIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.res_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateClear;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StateIdle);
  assign out_valid_o = out_valid_q;

  `LPHT_ASSERT(a_res_then_idle, clk_i, rst_ni, cmd_o.res_load |=> (state_q == StateIdle) && out_valid_q, "result load must leave a held result and an idle controller")
  `LPHT_ASSERT_NEVER(a_no_write_on_search, clk_i, rst_ni, cmd_o.ins_wr && (sts_i.is_search || !sts_i.hit), "slot written without an insert hit")
  `LPHT_ASSERT(a_read_then_check, clk_i, rst_ni, (state_q == StateRead) |=> (state_q == StateCheck), "home read not followed by a check")
  `LPHT_ASSERT_NEVER(a_no_clobber, clk_i, rst_ni, cmd_o.res_load && out_valid_q && !out_ready_i, "held result overwritten")

endmodule
